// ===== design/segment_segment_distance_squared_top_assert.svh =====
// assertion macros for the segment distance block
`ifndef SEGMENT_SEGMENT_DISTANCE_SQUARED_TOP_ASSERT_SVH
`define SEGMENT_SEGMENT_DISTANCE_SQUARED_TOP_ASSERT_SVH

// same-cycle implication, sampled on the block clock
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ssd_pkg.sv =====
package ssd_pkg;

    localparam int COORD_BITS      = 16;
    localparam int PARAM_FRAC_BITS = 16;

    localparam int CW     = COORD_BITS;
    localparam int DW     = CW + 1;
    localparam int PW     = 2 * DW;
    localparam int SW     = PW + 2;
    localparam int FB     = PARAM_FRAC_BITS;
    localparam int QW     = FB + 1;
    localparam int UPW    = DW + QW + 1;
    localparam int CMP_W  = DW + FB + 2;
    localparam int MIW    = (SW > CMP_W) ? SW : CMP_W;
    localparam int MW     = 2 * MIW;
    localparam int DIST_W = 36;

    // stage counts
    localparam int DIV_LAT = FB + 1;
    localparam int VEC_DLY = 8 + DIV_LAT;
    localparam int LAT     = VEC_DLY + 5;

    typedef logic signed [CW-1:0]    t_coord;
    typedef logic signed [DW-1:0]    t_diff;
    typedef logic signed [PW-1:0]    t_prod;
    typedef logic signed [SW-1:0]    t_dot;
    typedef logic signed [MIW-1:0]   t_mop;
    typedef logic signed [MW-1:0]    t_wide;
    typedef logic signed [UPW-1:0]   t_uprod;
    typedef logic [QW-1:0]           t_param;
    typedef logic [DIST_W-1:0]       t_dist;

    localparam t_param PARAM_ONE = t_param'(2 ** FB);

    typedef struct packed {
        t_diff [2:0] u;
        t_diff [2:0] v;
        t_diff [2:0] w;
    } t_vec;

    typedef struct packed {
        t_dot a;
        t_dot b;
        t_dot c;
        t_dot d;
        t_dot e;
    } t_dots;

endpackage

// ===== design/ssd_mul.sv =====
module ssd_mul (
    input  logic         i_clk,
    input  logic         i_en,
    input  ssd_pkg::t_mop  i_x,
    input  ssd_pkg::t_mop  i_y,
    output ssd_pkg::t_wide o_p
);
    import ssd_pkg::*;

    localparam int H = MIW / 2;

    // split y into an unsigned low half and a signed high half
    logic signed [MIW+H:0]       r_lo;
    logic signed [2*MIW-H-1:0]   r_hi;
    t_wide                       r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= i_x * $signed({1'b0, i_y[H-1:0]});
            r_hi <= i_x * $signed(i_y[MIW-1:H]);
            r_p  <= (t_wide'(r_hi) <<< H) + t_wide'(r_lo);
        end
    end

    assign o_p = r_p;

endmodule

// ===== design/ssd_div.sv =====
module ssd_div (
    input  logic            i_clk,
    input  logic            i_en,
    input  ssd_pkg::t_wide  i_num,
    input  ssd_pkg::t_wide  i_den,
    output ssd_pkg::t_param o_quot
);
    import ssd_pkg::*;

    typedef logic [MW-1:0] t_rem;

    t_rem          r_rem [DIV_LAT];
    t_rem          r_den [DIV_LAT];
    logic [FB-1:0] r_q   [DIV_LAT];
    logic          r_sat [DIV_LAT];

    logic n_skip;
    logic n_sat;

    always_comb begin
        n_skip = i_num[MW-1] || (i_num == t_wide'(0)) || i_den[MW-1] || (i_den == t_wide'(0));
        n_sat  = !n_skip && (i_num >= i_den);
    end

    // special cases run through with a zero remainder so every quotient bit comes out zero; saturation rides in r_sat
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (n_skip || n_sat) ? '0 : t_rem'(i_num);
            r_den[0] <= (n_skip || n_sat) ? t_rem'(1) : t_rem'(i_den);
            r_q[0]   <= '0;
            r_sat[0] <= n_sat;
        end
    end

    for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
        logic [MW:0] n_shift;
        logic        n_ge;

        always_comb begin
            n_shift = {r_rem[k-1], 1'b0};
            n_ge    = n_shift >= {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? t_rem'(n_shift - {1'b0, r_den[k-1]}) : t_rem'(n_shift);
                r_den[k] <= r_den[k-1];
                r_q[k]   <= {r_q[k-1][FB-2:0], n_ge};
                r_sat[k] <= r_sat[k-1];
            end
        end
    end

    assign o_quot = {r_sat[DIV_LAT-1], r_q[DIV_LAT-1]};

endmodule

// ===== design/segment_segment_distance_squared_top.sv =====
// squared closest distance between two 3d segments, with both clamped parameters
//
// input channel: i_valid / o_stall carry one item, the twelve Q8.8 endpoint
// coordinates of both segments. output channel: o_valid / i_stall carry one
// item per input, the Q20.16 squared distance and two Q1.16 parameters.
// an item is taken on a clock edge with valid high and stall low.
//
// throughput: one item per cycle while no finished item waits under i_stall.
// the pipeline depth is set by the parameter dividers (a special-case stage,
// then one quotient bit per stage, 17 stages) and the two 2-stage multiplier
// banks for the determinant terms and the distance squares.
//
// the whole pipeline advances together; while a finished item waits under
// i_stall, every stage holds and o_stall is raised, so nothing is lost or
// repeated. items keep flowing into empty stages whenever the output moves.
//
// reset clears the valid bits of every stage; data registers are not reset.
module segment_segment_distance_squared_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ssd_pkg::t_coord i_first_start_x,
    input  ssd_pkg::t_coord i_first_start_y,
    input  ssd_pkg::t_coord i_first_start_z,
    input  ssd_pkg::t_coord i_first_end_x,
    input  ssd_pkg::t_coord i_first_end_y,
    input  ssd_pkg::t_coord i_first_end_z,
    input  ssd_pkg::t_coord i_second_start_x,
    input  ssd_pkg::t_coord i_second_start_y,
    input  ssd_pkg::t_coord i_second_start_z,
    input  ssd_pkg::t_coord i_second_end_x,
    input  ssd_pkg::t_coord i_second_end_y,
    input  ssd_pkg::t_coord i_second_end_z,
    output logic            o_valid,
    input  logic            i_stall,
    output ssd_pkg::t_dist  o_distance_squared,
    output ssd_pkg::t_param o_first_param,
    output ssd_pkg::t_param o_second_param
);
    import ssd_pkg::*;

    logic             en;
    logic [LAT-1:0]   r_valid;

    assign en      = !(r_valid[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_valid[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[LAT-2:0], i_valid};
        end
    end

    // stage 1: direction and offset vectors
    t_coord p0 [3], p1 [3], q0 [3], q1 [3];
    t_vec   r_vec [VEC_DLY];

    assign p0 = '{i_first_start_x, i_first_start_y, i_first_start_z};
    assign p1 = '{i_first_end_x, i_first_end_y, i_first_end_z};
    assign q0 = '{i_second_start_x, i_second_start_y, i_second_start_z};
    assign q1 = '{i_second_end_x, i_second_end_y, i_second_end_z};

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_vec[0].u[i] <= t_diff'(p1[i]) - t_diff'(p0[i]);
                r_vec[0].v[i] <= t_diff'(q1[i]) - t_diff'(q0[i]);
                r_vec[0].w[i] <= t_diff'(p0[i]) - t_diff'(q0[i]);
            end
            for (int k = 1; k < VEC_DLY; k++) begin
                r_vec[k] <= r_vec[k-1];
            end
        end
    end

    // stage 2: component products
    t_prod r2_uu [3], r2_uv [3], r2_vv [3], r2_uw [3], r2_vw [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_uu[i] <= r_vec[0].u[i] * r_vec[0].u[i];
                r2_uv[i] <= r_vec[0].u[i] * r_vec[0].v[i];
                r2_vv[i] <= r_vec[0].v[i] * r_vec[0].v[i];
                r2_uw[i] <= r_vec[0].u[i] * r_vec[0].w[i];
                r2_vw[i] <= r_vec[0].v[i] * r_vec[0].w[i];
            end
        end
    end

    // stage 3: dot products
    t_dots r3_dots, r4_dots, r5_dots, r6_dots, r7_dots;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dots.a <= t_dot'(r2_uu[0]) + t_dot'(r2_uu[1]) + t_dot'(r2_uu[2]);
            r3_dots.b <= t_dot'(r2_uv[0]) + t_dot'(r2_uv[1]) + t_dot'(r2_uv[2]);
            r3_dots.c <= t_dot'(r2_vv[0]) + t_dot'(r2_vv[1]) + t_dot'(r2_vv[2]);
            r3_dots.d <= t_dot'(r2_uw[0]) + t_dot'(r2_uw[1]) + t_dot'(r2_uw[2]);
            r3_dots.e <= t_dot'(r2_vw[0]) + t_dot'(r2_vw[1]) + t_dot'(r2_vw[2]);
            r4_dots   <= r3_dots;
            r5_dots   <= r4_dots;
            r6_dots   <= r5_dots;
            r7_dots   <= r6_dots;
        end
    end

    // stages 4-5: determinant and numerator products
    t_mop  ma, mb, mc, md, me;
    t_wide p_ac, p_bb, p_be, p_cd, p_ae, p_bd;

    assign ma = t_mop'(r3_dots.a);
    assign mb = t_mop'(r3_dots.b);
    assign mc = t_mop'(r3_dots.c);
    assign md = t_mop'(r3_dots.d);
    assign me = t_mop'(r3_dots.e);

    ssd_mul u_mul_ac (.i_clk, .i_en(en), .i_x(ma), .i_y(mc), .o_p(p_ac));
    ssd_mul u_mul_bb (.i_clk, .i_en(en), .i_x(mb), .i_y(mb), .o_p(p_bb));
    ssd_mul u_mul_be (.i_clk, .i_en(en), .i_x(mb), .i_y(me), .o_p(p_be));
    ssd_mul u_mul_cd (.i_clk, .i_en(en), .i_x(mc), .i_y(md), .o_p(p_cd));
    ssd_mul u_mul_ae (.i_clk, .i_en(en), .i_x(ma), .i_y(me), .o_p(p_ae));
    ssd_mul u_mul_bd (.i_clk, .i_en(en), .i_x(mb), .i_y(md), .o_p(p_bd));

    // stage 6
    t_wide r6_det, r6_sn, r6_tn;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_det <= p_ac - p_bb;
            r6_sn  <= p_be - p_cd;
            r6_tn  <= p_ae - p_bd;
        end
    end

    // stage 7: parallel case and clamp of s against its edges
    t_wide n7_sn, n7_sd, n7_tn, n7_td;
    t_wide r7_sn, r7_sd, r7_tn, r7_td;

    always_comb begin
        n7_sn = r6_sn;
        n7_sd = r6_det;
        n7_tn = r6_tn;
        n7_td = r6_det;
        priority if (r6_det[MW-1] || (r6_det == t_wide'(0))) begin
            n7_sn = '0;
            n7_sd = t_wide'(1);
            n7_tn = t_wide'(r6_dots.e);
            n7_td = t_wide'(r6_dots.c);
        end else if (r6_sn[MW-1]) begin
            n7_sn = '0;
            n7_tn = t_wide'(r6_dots.e);
            n7_td = t_wide'(r6_dots.c);
        end else if (r6_sn > r6_det) begin
            n7_sn = r6_det;
            n7_tn = t_wide'(r6_dots.e) + t_wide'(r6_dots.b);
            n7_td = t_wide'(r6_dots.c);
        end else begin
            n7_sn = r6_sn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sn <= n7_sn;
            r7_sd <= n7_sd;
            r7_tn <= n7_tn;
            r7_td <= n7_td;
        end
    end

    // stage 8: clamp of t, which may re-solve s on an edge
    t_wide n8_sn, n8_sd, n8_tn, negd, negdb, dot_a;
    t_wide r8_sn, r8_sd, r8_tn, r8_td;

    always_comb begin
        negd  = -t_wide'(r7_dots.d);
        negdb = negd + t_wide'(r7_dots.b);
        dot_a = t_wide'(r7_dots.a);
        n8_sn = r7_sn;
        n8_sd = r7_sd;
        n8_tn = r7_tn;
        priority if (r7_tn[MW-1]) begin
            n8_tn = '0;
            priority if (negd[MW-1]) begin
                n8_sn = '0;
            end else if (negd > dot_a) begin
                n8_sn = r7_sd;
            end else begin
                n8_sn = negd;
                n8_sd = dot_a;
            end
        end else if (r7_tn > r7_td) begin
            n8_tn = r7_td;
            priority if (negdb[MW-1]) begin
                n8_sn = '0;
            end else if (negdb > dot_a) begin
                n8_sn = r7_sd;
            end else begin
                n8_sn = negdb;
                n8_sd = dot_a;
            end
        end else begin
            n8_tn = r7_tn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_sn <= n8_sn;
            r8_sd <= n8_sd;
            r8_tn <= n8_tn;
            r8_td <= r7_td;
        end
    end

    // stages 9-25: parameter quotients
    t_param sc, tc;

    ssd_div u_div_s (.i_clk, .i_en(en), .i_num(r8_sn), .i_den(r8_sd), .o_quot(sc));
    ssd_div u_div_t (.i_clk, .i_en(en), .i_num(r8_tn), .i_den(r8_td), .o_quot(tc));

    // stage 26: points on both segments relative to the offset
    t_uprod r26_us [3], r26_vt [3];
    t_diff  r26_w [3];
    t_param r26_sc, r26_tc, r27_sc, r27_tc, r28_sc, r28_tc, r29_sc, r29_tc;
    t_param r_first_param, r_second_param;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r26_us[i] <= r_vec[VEC_DLY-1].u[i] * $signed({1'b0, sc});
                r26_vt[i] <= r_vec[VEC_DLY-1].v[i] * $signed({1'b0, tc});
                r26_w[i]  <= r_vec[VEC_DLY-1].w[i];
            end
            r26_sc         <= sc;
            r26_tc         <= tc;
            r27_sc         <= r26_sc;
            r27_tc         <= r26_tc;
            r28_sc         <= r27_sc;
            r28_tc         <= r27_tc;
            r29_sc         <= r28_sc;
            r29_tc         <= r28_tc;
            r_first_param  <= r29_sc;
            r_second_param <= r29_tc;
        end
    end

    // stage 27: offset components, exact with FB extra fraction bits
    t_mop r27_comp [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r27_comp[i] <= (t_mop'(r26_w[i]) <<< FB) + t_mop'(r26_us[i]) - t_mop'(r26_vt[i]);
            end
        end
    end

    // stages 28-29: squares
    t_wide sq [3];

    for (genvar i = 0; i < 3; i++) begin : g_sq
        ssd_mul u_mul_sq (
            .i_clk,
            .i_en (en),
            .i_x  (r27_comp[i]),
            .i_y  (r27_comp[i]),
            .o_p  (sq[i])
        );
    end

    // stage 30: sum, drop the extra fraction bits
    logic [MW+1:0] sum_sq;
    t_dist         r_dist;

    assign sum_sq = (MW+2)'(sq[0]) + (MW+2)'(sq[1]) + (MW+2)'(sq[2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist <= sum_sq[2*FB +: DIST_W];
        end
    end

    assign o_distance_squared = r_dist;
    assign o_first_param      = r_first_param;
    assign o_second_param     = r_second_param;

endmodule

// ===== design/ssd_checker.sv =====
`include "segment_segment_distance_squared_top_assert.svh"

module ssd_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input ssd_pkg::t_dist  o_distance_squared,
    input ssd_pkg::t_param o_first_param,
    input ssd_pkg::t_param o_second_param
);
    import ssd_pkg::*;

    `SSD_ASSERT_NEXT(a_out_held, o_valid && i_stall, o_valid, "stalled output item dropped")
    `SSD_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(o_distance_squared) && $stable(o_first_param) && $stable(o_second_param), "stalled output item changed")
    `SSD_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall, "input stalled without a blocked output item")
    `SSD_ASSERT_NOW(a_param_range, o_valid, (o_first_param <= PARAM_ONE) && (o_second_param <= PARAM_ONE), "segment parameter above one")

endmodule

bind segment_segment_distance_squared_top ssd_checker u_ssd_checker (.*);

// ===== verif/segment_segment_distance_squared_top_test.sv =====
module segment_segment_distance_squared_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssd_pkg::*;

    typedef struct {
        t_coord c [12];
    } seg_pair_t;

    typedef struct {
        t_dist  dsq;
        t_param sp;
        t_param tp;
    } closest_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    t_coord crd [12];
    t_dist  o_distance_squared;
    t_param o_first_param, o_second_param;

    closest_t closest_q [$];
    int fails = 0;
    int stall_left = 0;
    bit idle_en = 1'b1;
    bit hold_rx = 1'b0;

    always #6 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < 12; k++) crd[k] = '0;
    end

    segment_segment_distance_squared_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_first_start_x(crd[0]), .i_first_start_y(crd[1]), .i_first_start_z(crd[2]),
        .i_first_end_x(crd[3]), .i_first_end_y(crd[4]), .i_first_end_z(crd[5]),
        .i_second_start_x(crd[6]), .i_second_start_y(crd[7]),
        .i_second_start_z(crd[8]),
        .i_second_end_x(crd[9]), .i_second_end_y(crd[10]), .i_second_end_z(crd[11]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_distance_squared(o_distance_squared),
        .o_first_param(o_first_param), .o_second_param(o_second_param)
    );

    // floor(n * 2^16 / d), saturated, zero for zero or negative operands
    function automatic t_param seg_param(logic signed [127:0] n, logic signed [127:0] d);
        logic signed [127:0] q;
        if (n <= 0 || d <= 0) return '0;
        if (n >= d) return PARAM_ONE;
        q = (n <<< FB) / d;
        return t_param'(q);
    endfunction

    function automatic closest_t closest_points(seg_pair_t p);
        closest_t r;
        logic signed [63:0] u [3], v [3], w [3];
        logic signed [63:0] a, b, c, d, e, comp;
        logic signed [127:0] det, sn, sd, tn, td, negd, negdb, sum;
        a = 0; b = 0; c = 0; d = 0; e = 0;
        for (int k = 0; k < 3; k++) begin
            u[k] = 64'(p.c[3+k]) - 64'(p.c[k]);
            v[k] = 64'(p.c[9+k]) - 64'(p.c[6+k]);
            w[k] = 64'(p.c[k]) - 64'(p.c[6+k]);
        end
        for (int k = 0; k < 3; k++) begin
            a += u[k] * u[k];
            b += u[k] * v[k];
            c += v[k] * v[k];
            d += u[k] * w[k];
            e += v[k] * w[k];
        end
        det = 128'(a) * 128'(c) - 128'(b) * 128'(b);
        sd = det;
        td = det;
        if (det <= 0) begin
            // parallel segments
            sn = 0; sd = 1; tn = e; td = c;
        end else begin
            sn = 128'(b) * 128'(e) - 128'(c) * 128'(d);
            tn = 128'(a) * 128'(e) - 128'(b) * 128'(d);
            if (sn < 0) begin
                sn = 0; tn = e; td = c;
            end else if (sn > sd) begin
                sn = sd; tn = 128'(e) + 128'(b); td = c;
            end
        end
        negd = -128'(d);
        negdb = negd + 128'(b);
        if (tn < 0) begin
            tn = 0;
            if (negd < 0) sn = 0;
            else if (negd > a) sn = sd;
            else begin sn = negd; sd = a; end
        end else if (tn > td) begin
            tn = td;
            if (negdb < 0) sn = 0;
            else if (negdb > a) sn = sd;
            else begin sn = negdb; sd = a; end
        end
        r.sp = seg_param(sn, sd);
        r.tp = seg_param(tn, td);
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            comp = (w[k] <<< FB) + u[k] * 64'(r.sp) - v[k] * 64'(r.tp);
            sum += 128'(comp) * 128'(comp);
        end
        r.dsq = t_dist'(sum >>> (2 * FB));
        return r;
    endfunction

    task automatic send_pair(seg_pair_t p);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            repeat (gap) @(negedge i_clk);
        end
        for (int k = 0; k < 12; k++) crd[k] = p.c[k];
        i_valid = 1'b1;
        closest_q.push_back(closest_points(p));
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // receiver stall: random bursts, or a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (hold_rx) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        closest_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (closest_q.size() == 0) begin
                $error("result item with nothing expected");
                fails++;
            end else begin
                want = closest_q.pop_front();
                if (o_distance_squared !== want.dsq) begin
                    $error("distance_squared exp %0d got %0d", want.dsq, o_distance_squared);
                    fails++;
                end
                if (o_first_param !== want.sp) begin
                    $error("first_param exp %0d got %0d", want.sp, o_first_param);
                    fails++;
                end
                if (o_second_param !== want.tp) begin
                    $error("second_param exp %0d got %0d", want.tp, o_second_param);
                    fails++;
                end
            end
        end
    end

    function automatic t_coord rnd_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(0, 511)) - 16'sd256;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return t_coord'($urandom_range(0, 15)) - 16'sd8;
        endcase
    endfunction

    function automatic seg_pair_t rnd_pair();
        seg_pair_t p;
        int mode, kind;
        mode = $urandom_range(0, 3);
        kind = $urandom_range(0, 5);
        for (int k = 0; k < 12; k++)
            p.c[k] = ($urandom_range(0, 5) == 0) ? rnd_coord($urandom_range(0, 3))
                                                 : rnd_coord(mode);
        // degenerate or parallel shapes now and then
        if (kind == 0) for (int k = 0; k < 3; k++) p.c[3+k] = p.c[k];
        if (kind == 1) for (int k = 0; k < 3; k++) p.c[9+k] = p.c[6+k];
        if (kind == 2 && mode != 2) for (int k = 0; k < 3; k++)
            p.c[9+k] = p.c[6+k] + (p.c[3+k] - p.c[k]);
        return p;
    endfunction

    task automatic test_directed();
        seg_pair_t p;
        int dirs [6][12] = '{
            '{0,0,0, 256,0,0, 0,256,0, 256,256,0},
            '{0,0,0, 256,0,0, 128,-256,256, 128,256,256},
            '{0,0,0, 0,0,0, 0,0,0, 0,0,0},
            '{10,20,30, 10,20,30, -5,7,9, 100,-40,3},
            '{0,0,0, 256,0,0, 512,0,0, 1024,0,0},
            '{0,0,0, 256,0,0, -512,256,0, -256,256,0}
        };
        for (int n = 0; n < 6; n++) begin
            for (int k = 0; k < 12; k++) p.c[k] = t_coord'(dirs[n][k]);
            send_pair(p);
        end
        for (int n = 0; n < 8; n++) begin
            for (int k = 0; k < 12; k++)
                p.c[k] = ((n >> (k % 3)) & 1) ^ (k >= 6) ? 16'sh7fff : 16'sh8000;
            send_pair(p);
        end
        for (int k = 0; k < 12; k++) p.c[k] = 16'sh8000;
        p.c[3] = 16'sh7fff;
        send_pair(p);
        p.c[9] = 16'sh7fff;
        send_pair(p);
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) send_pair(rnd_pair());
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (80) @(negedge i_clk);
                hold_rx = 1'b0;
            end
            test_random(60);
        join
    endtask

    initial begin
        int guard;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(400);
        test_backpressure();
        idle_en = 1'b0;
        test_random(240);
        guard = 0;
        while (closest_q.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LAT + 10) @(posedge i_clk);
        if (fails == 0 && closest_q.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #(5ms);
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/ssd_pkg.sv
design/ssd_mul.sv
design/ssd_div.sv
design/segment_segment_distance_squared_top.sv
design/ssd_checker.sv
verif/segment_segment_distance_squared_top_test.sv
